// ===== hw/rtl/msc_pkg.sv =====
// Shared types and constants for the motion sleep classifier.
// No dependencies; imported by msc_state and motion_sleep_classifier.

package msc_pkg;

  localparam int unsigned AccelW  = 16;
  localparam int unsigned StepW   = 16;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned CountW  = 16;
  localparam int unsigned MagW    = 17;
  localparam int unsigned SumW    = 18;
  localparam int unsigned PhaseW  = 6;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [MagW-1:0]    StillThreshold   = MagW'(120);
  localparam logic [CountW-1:0]  SecondsPerMinute = CountW'(60);
  localparam logic [CountW-1:0]  DeepStillSeconds = CountW'(60 * 10);
  localparam logic [PhaseW-1:0]  PhaseLast        = PhaseW'(60 - 1);

  localparam logic [HourW-1:0] WinStartReset = HourW'(20);
  localparam logic [HourW-1:0] WinEndReset   = HourW'(8);

  // register indexes on the config port
  localparam logic [CfgAddrW-1:0] RegWinStart     = 2'd0;
  localparam logic [CfgAddrW-1:0] RegWinEnd       = 2'd1;
  localparam logic [CfgAddrW-1:0] RegCarriedLight = 2'd2;
  localparam logic [CfgAddrW-1:0] RegCarriedDeep  = 2'd3;

  typedef struct packed {
    logic                       wearing;
    logic                       charging;
    logic [MinuteW-1:0]         minute;
    logic [HourW-1:0]           hour;
    logic [StepW-1:0]           step_count;
    logic signed [AccelW-1:0]   accel_z;
    logic signed [AccelW-1:0]   accel_y;
    logic signed [AccelW-1:0]   accel_x;
  } sample_t;

  typedef struct packed {
    logic              skipped;
    logic              record_saved;
    logic [CountW-1:0] deep_total;
    logic [CountW-1:0] light_total;
  } result_t;

  typedef struct packed {
    logic                we;
    logic [CfgAddrW-1:0] addr;
    logic [CfgDataW-1:0] wdata;
  } cfg_wr_t;

endpackage

// ===== hw/rtl/motion_sleep_classifier.sv =====
// Motion sleep classifier top level: input register, update logic, result register.
// Depends on msc_pkg and msc_state.
//
// Usage:
//   Slave stream s_axis carries one sample per request: tdata holds the axes, step
//   total, hour and minute; tuser holds the charging and wearing flags. Master stream
//   m_axis returns exactly one result per sample: the light and deep totals in tdata,
//   record_saved and skipped in tuser.
//   The config port writes one register per cycle with cfg_we_i; write only while no
//   sample is in flight. There is no read-back.
//   A sample goes through the input register, then the result register, to m_axis.
//   Throughput: one sample per cycle while the receiver takes results; the state
//   update is combinational between the input register and the result register.
//   When the receiver stalls, the result register holds its request and the input
//   register fills; s_axis_tready drops only when both are full, and nothing is lost.
//   Reset clears all counters and valid flags and loads the window hours 20 and 8 and
//   zero carried totals.

module motion_sleep_classifier
  import msc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], step_count[63:48],
  // hour[68:64], minute[74:69], zero fill [79:75]
  input  logic [79:0]         s_axis_tdata,
  // charging[0], wearing[1]
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // light_total[15:0], deep_total[31:16]
  output logic [31:0]         m_axis_tdata,
  // record_saved[0], skipped[1]
  output logic [1:0]          m_axis_tuser,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic    in_vld_q, out_vld_q;
  sample_t in_q;
  result_t out_q, result;
  logic    out_rdy, adv, in_take;
  cfg_wr_t cfg;

  assign out_rdy       = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && out_rdy;
  assign s_axis_tready = !in_vld_q || out_rdy;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign cfg.we    = cfg_we_i;
  assign cfg.addr  = cfg_addr_i;
  assign cfg.wdata = cfg_wdata_i;

  msc_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .adv_i    (adv),
    .sample_i (in_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_rdy) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.accel_x    <= s_axis_tdata[15:0];
      in_q.accel_y    <= s_axis_tdata[31:16];
      in_q.accel_z    <= s_axis_tdata[47:32];
      in_q.step_count <= s_axis_tdata[63:48];
      in_q.hour       <= s_axis_tdata[68:64];
      in_q.minute     <= s_axis_tdata[74:69];
      in_q.charging   <= s_axis_tuser[0];
      in_q.wearing    <= s_axis_tuser[1];
    end
    if (adv) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.deep_total, out_q.light_total};
  assign m_axis_tuser  = {out_q.skipped, out_q.record_saved};

endmodule

// ===== hw/rtl/msc_state.sv =====
// Classifier state, config registers and the per-sample update logic.
// Depends on msc_pkg.

module msc_state
  import msc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  logic    adv_i,     // sample consumed this cycle, commit state
  input  sample_t sample_i,
  output result_t result_o
);

  logic [HourW-1:0]  win_start_q, win_start_d;
  logic [HourW-1:0]  win_end_q, win_end_d;
  logic [CountW-1:0] carried_light_q, carried_light_d;
  logic [CountW-1:0] carried_deep_q, carried_deep_d;
  logic              carry_cleared_q, carry_cleared_d;

  logic [MagW-1:0]   last_mag_q, last_mag_d;
  logic [CountW-1:0] still_q, still_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [StepW-1:0]  prev_steps_q, prev_steps_d;
  logic              armed_q, armed_d;
  logic [CountW-1:0] light_min_q, light_min_d;
  logic [CountW-1:0] deep_min_q, deep_min_d;
  logic [CountW-1:0] light_sum_q, light_sum_d;
  logic [CountW-1:0] deep_sum_q, deep_sum_d;

  logic signed [SumW-1:0] axis_sum;
  logic [SumW-1:0]        axis_abs;
  logic [MagW-1:0]        mag, mag_diff;
  logic [CountW-1:0]      still_nx;
  logic                   skip, in_window, win_open, sleep_min, do_clear;
  logic [CountW-1:0]      cl, cd, light_inc, deep_inc;

  always_comb begin
    axis_sum = SumW'(sample_i.accel_x) + SumW'(sample_i.accel_y) + SumW'(sample_i.accel_z);
    axis_abs = axis_sum[SumW-1] ? -axis_sum : axis_sum;
    mag      = axis_abs[MagW-1:0];
    mag_diff = (last_mag_q > mag) ? (last_mag_q - mag) : (mag - last_mag_q);
    still_nx = (mag_diff >= StillThreshold) ? '0 : still_q + CountW'(1);

    skip      = sample_i.charging | ~sample_i.wearing;
    in_window = (phase_q == '0) &&
                ((sample_i.hour >= win_start_q) || (sample_i.hour < win_end_q));
    win_open  = (sample_i.hour == win_start_q) && (sample_i.minute == '0);
    do_clear  = in_window && win_open && armed_q;
    sleep_min = in_window && !win_open && (prev_steps_q == sample_i.step_count) &&
                (still_nx >= SecondsPerMinute);

    cl = carry_cleared_q ? '0 : carried_light_q;
    cd = carry_cleared_q ? '0 : carried_deep_q;
    light_inc = light_min_q;
    deep_inc  = deep_min_q;
    if (still_nx >= DeepStillSeconds) begin
      deep_inc = deep_min_q + CountW'(1);
    end else begin
      light_inc = light_min_q + CountW'(1);
    end
  end

  always_comb begin
    win_start_d     = win_start_q;
    win_end_d       = win_end_q;
    carried_light_d = carried_light_q;
    carried_deep_d  = carried_deep_q;
    carry_cleared_d = carry_cleared_q;
    last_mag_d      = last_mag_q;
    still_d         = still_q;
    phase_d         = phase_q;
    prev_steps_d    = prev_steps_q;
    armed_d         = armed_q;
    light_min_d     = light_min_q;
    deep_min_d      = deep_min_q;
    light_sum_d     = light_sum_q;
    deep_sum_d      = deep_sum_q;

    if (cfg_i.we) begin
      unique case (cfg_i.addr)
        RegWinStart: win_start_d = cfg_i.wdata[HourW-1:0];
        RegWinEnd:   win_end_d   = cfg_i.wdata[HourW-1:0];
        RegCarriedLight: begin
          carried_light_d = cfg_i.wdata;
          carry_cleared_d = 1'b0;
        end
        RegCarriedDeep: begin
          carried_deep_d  = cfg_i.wdata;
          carry_cleared_d = 1'b0;
        end
        default: ;
      endcase
    end

    if (adv_i && !skip) begin
      still_d      = still_nx;
      last_mag_d   = mag;
      phase_d      = (phase_q >= PhaseLast) ? '0 : phase_q + PhaseW'(1);
      prev_steps_d = sample_i.step_count;
      if (in_window && !win_open) begin
        armed_d = 1'b1;
      end
      if (do_clear) begin
        armed_d         = 1'b0;
        last_mag_d      = '0;
        still_d         = '0;
        light_min_d     = '0;
        deep_min_d      = '0;
        light_sum_d     = '0;
        deep_sum_d      = '0;
        carried_light_d = '0;
        carried_deep_d  = '0;
        carry_cleared_d = 1'b1;
      end
      if (sleep_min) begin
        light_min_d = light_inc;
        deep_min_d  = deep_inc;
        light_sum_d = light_inc + cl;
        deep_sum_d  = deep_inc + cd;
      end
    end
  end

  always_comb begin
    result_o.skipped      = skip;
    result_o.record_saved = !skip && (do_clear || sleep_min);
    result_o.light_total  = skip ? light_sum_q : light_sum_d;
    result_o.deep_total   = skip ? deep_sum_q : deep_sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q     <= WinStartReset;
      win_end_q       <= WinEndReset;
      carried_light_q <= '0;
      carried_deep_q  <= '0;
      carry_cleared_q <= 1'b0;
      last_mag_q      <= '0;
      still_q         <= '0;
      phase_q         <= '0;
      prev_steps_q    <= '0;
      armed_q         <= 1'b0;
      light_min_q     <= '0;
      deep_min_q      <= '0;
      light_sum_q     <= '0;
      deep_sum_q      <= '0;
    end else begin
      win_start_q     <= win_start_d;
      win_end_q       <= win_end_d;
      carried_light_q <= carried_light_d;
      carried_deep_q  <= carried_deep_d;
      carry_cleared_q <= carry_cleared_d;
      last_mag_q      <= last_mag_d;
      still_q         <= still_d;
      phase_q         <= phase_d;
      prev_steps_q    <= prev_steps_d;
      armed_q         <= armed_d;
      light_min_q     <= light_min_d;
      deep_min_q      <= deep_min_d;
      light_sum_q     <= light_sum_d;
      deep_sum_q      <= deep_sum_d;
    end
  end

  // phase counts 0..59 only
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhaseLast)
    else $error("second phase out of range");

  // an ignored sample leaves the tracking state alone
  a_skip_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && skip && !cfg_i.we |=> $stable(still_q) && $stable(phase_q) &&
    $stable(light_sum_q) && $stable(deep_sum_q) && $stable(armed_q))
    else $error("state changed on skipped sample");

  // window opening leaves all totals at zero and disarms
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !skip && do_clear |=> light_sum_q == '0 && deep_sum_q == '0 &&
    !armed_q && carry_cleared_q)
    else $error("window opening did not clear counters");

  // a counted minute bumps exactly one of the two minute counters
  a_one_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !skip && sleep_min |=>
    (light_min_q != $past(light_min_q)) != (deep_min_q != $past(deep_min_q)))
    else $error("sleep minute not counted once");

endmodule
